// ===== rtl/grid_city_block_distance_transform_top_defines.svh =====
// assertion macros shared by the distance transform rtl
// expects clk and rst_n in the scope of each use
`ifndef GRID_CITY_BLOCK_DISTANCE_TRANSFORM_TOP_DEFINES_SVH
`define GRID_CITY_BLOCK_DISTANCE_TRANSFORM_TOP_DEFINES_SVH

// consequent holds in the same cycle
`define GCBDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define GCBDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gcbdt_pkg.sv =====
// shared constants, types and codes for the distance transform block
// no dependencies
package gcbdt_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CNT_W    = 7;
  localparam int DIST_W   = 7;
  localparam int WORK_W   = 8;
  localparam int REQ_W    = 2;

  localparam logic [WORK_W-1:0] FAR      = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD_RD,
    ST_FWD_WR,
    ST_BWD_RD,
    ST_BWD_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
  } grid_cfg_t;

  typedef struct packed {
    logic accept;
    logic sel_input;
    logic dir_bwd;
    logic fwd_init;
    logic bwd_init;
    logic step;
    logic wr_fwd;
    logic wr_bwd;
    logic commit;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic out_valid;
  } dp_sts_t;

endpackage

// ===== rtl/gcbdt_cfg.sv =====
// configuration registers behind the apb-style port
// depends on gcbdt_pkg
module gcbdt_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output gcbdt_pkg::grid_cfg_t  grid_cfg
);

  logic [gcbdt_pkg::CNT_W-1:0] rows_r;
  logic [gcbdt_pkg::CNT_W-1:0] cols_r;
  logic                        wr_en;
  logic                        sel;

  assign cfg_pready = 1'b1;
  assign sel        = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= gcbdt_pkg::CNT_W'(gcbdt_pkg::MAX_ROWS);
      cols_r <= gcbdt_pkg::CNT_W'(gcbdt_pkg::MAX_COLS);
    end else if (wr_en) begin
      unique case (sel)
        gcbdt_pkg::REG_ROWS: rows_r <= cfg_pwdata[gcbdt_pkg::CNT_W-1:0];
        gcbdt_pkg::REG_COLS: cols_r <= cfg_pwdata[gcbdt_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (sel)
      gcbdt_pkg::REG_ROWS: cfg_prdata[gcbdt_pkg::CNT_W-1:0] = rows_r;
      gcbdt_pkg::REG_COLS: cfg_prdata[gcbdt_pkg::CNT_W-1:0] = cols_r;
      default: ;
    endcase
  end

  // zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (rows_r == '0) begin
      grid_cfg.rows = gcbdt_pkg::CNT_W'(1);
    end else if (rows_r > gcbdt_pkg::CNT_W'(gcbdt_pkg::MAX_ROWS)) begin
      grid_cfg.rows = gcbdt_pkg::CNT_W'(gcbdt_pkg::MAX_ROWS);
    end else begin
      grid_cfg.rows = rows_r;
    end
    if (cols_r == '0) begin
      grid_cfg.cols = gcbdt_pkg::CNT_W'(1);
    end else if (cols_r > gcbdt_pkg::CNT_W'(gcbdt_pkg::MAX_COLS)) begin
      grid_cfg.cols = gcbdt_pkg::CNT_W'(gcbdt_pkg::MAX_COLS);
    end else begin
      grid_cfg.cols = cols_r;
    end
  end

endmodule

// ===== rtl/gcbdt_ctrl.sv =====
// controller: sequences item handling and the two raster passes
// depends on gcbdt_pkg and the assertion macro header
`include "grid_city_block_distance_transform_top_defines.svh"

module gcbdt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [gcbdt_pkg::REQ_W-1:0]   in_req_type,
  output logic                          in_stall,
  input  logic                          out_stall,
  input  gcbdt_pkg::dp_sts_t            sts,
  output gcbdt_pkg::ctrl_cmd_t          cmd
);

  gcbdt_pkg::state_t state_r;
  gcbdt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcbdt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    cmd.sel_input = (state_r == gcbdt_pkg::ST_IDLE);
    cmd.dir_bwd   = (state_r == gcbdt_pkg::ST_BWD_RD) || (state_r == gcbdt_pkg::ST_BWD_WR);
    unique case (state_r)
      gcbdt_pkg::ST_IDLE: begin
        in_stall   = !(!sts.out_valid || !out_stall);
        cmd.accept = in_valid && !in_stall;
        if (cmd.accept) begin
          if (in_req_type == gcbdt_pkg::REQ_COMPUTE) begin
            cmd.fwd_init = 1'b1;
            state_nxt    = gcbdt_pkg::ST_FWD_RD;
          end else begin
            state_nxt = gcbdt_pkg::ST_RESP;
          end
        end
      end
      gcbdt_pkg::ST_FWD_RD: begin
        state_nxt = gcbdt_pkg::ST_FWD_WR;
      end
      gcbdt_pkg::ST_FWD_WR: begin
        cmd.wr_fwd = 1'b1;
        if (sts.last_cell) begin
          cmd.bwd_init = 1'b1;
          state_nxt    = gcbdt_pkg::ST_BWD_RD;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = gcbdt_pkg::ST_FWD_RD;
        end
      end
      gcbdt_pkg::ST_BWD_RD: begin
        state_nxt = gcbdt_pkg::ST_BWD_WR;
      end
      gcbdt_pkg::ST_BWD_WR: begin
        cmd.wr_bwd = 1'b1;
        if (sts.last_cell) begin
          cmd.commit = 1'b1;
          state_nxt  = gcbdt_pkg::ST_RESP;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = gcbdt_pkg::ST_BWD_RD;
        end
      end
      gcbdt_pkg::ST_RESP: begin
        cmd.out_load = 1'b1;
        state_nxt    = gcbdt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gcbdt_pkg::ST_IDLE;
      end
    endcase
  end

  `GCBDT_ASSERT_NEXT(a_item_to_resp, cmd.accept && (in_req_type != gcbdt_pkg::REQ_COMPUTE), state_r == gcbdt_pkg::ST_RESP, "single access item did not go to response")
  `GCBDT_ASSERT_NEXT(a_commit_to_resp, cmd.commit, state_r == gcbdt_pkg::ST_RESP, "transform end did not go to response")
  `GCBDT_ASSERT_NOW(a_resp_out_free, state_r == gcbdt_pkg::ST_RESP, !sts.out_valid, "output register busy at response")

endmodule

// ===== rtl/gcbdt_dp.sv =====
// datapath: obstacle and distance memories, raster counters, relax logic, output register
// depends on gcbdt_pkg and the assertion macro header
`include "grid_city_block_distance_transform_top_defines.svh"

module gcbdt_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gcbdt_pkg::ctrl_cmd_t           cmd,
  output gcbdt_pkg::dp_sts_t             sts,
  input  gcbdt_pkg::grid_cfg_t           grid_cfg,
  input  logic [gcbdt_pkg::REQ_W-1:0]    in_req_type,
  input  logic [gcbdt_pkg::ROW_W-1:0]    in_row_index,
  input  logic [gcbdt_pkg::COL_W-1:0]    in_col_index,
  input  logic                           in_is_obstacle,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [gcbdt_pkg::DIST_W-1:0]   out_distance,
  output logic                           out_infinite,
  output logic                           out_addr_error
);

  localparam int W  = gcbdt_pkg::WORK_W;
  localparam int RW = gcbdt_pkg::ROW_W;
  localparam int CW = gcbdt_pkg::COL_W;
  localparam int AW = gcbdt_pkg::ADDR_W;

  logic                         obs_mem [gcbdt_pkg::CELLS];
  logic [W-1:0]                 dist_mem [gcbdt_pkg::CELLS];

  logic [RW-1:0]                row_r;
  logic [CW-1:0]                col_r;
  logic [RW-1:0]                rows_m1;
  logic [CW-1:0]                cols_m1;
  logic [AW-1:0]                own_addr;
  logic [AW-1:0]                nb_addr;
  logic [AW-1:0]                in_addr;
  logic [AW-1:0]                addr_b;
  logic [RW-1:0]                nb_row;

  logic                         obs_rd_r;
  logic [W-1:0]                 rd_a_r;
  logic [W-1:0]                 rd_b_r;
  logic [W-1:0]                 prev_r;
  logic                         found_r;
  logic                         any_obstacle_r;
  logic [gcbdt_pkg::REQ_W-1:0]  req_r;
  logic                         err_r;
  logic                         in_err;

  logic [W-1:0]                 base;
  logic [W-1:0]                 mid;
  logic [W-1:0]                 d_nxt;
  logic                         vert_ok;
  logic                         horz_ok;

  logic                         out_valid_r;
  logic [gcbdt_pkg::DIST_W-1:0] out_distance_r;
  logic                         out_infinite_r;
  logic                         out_addr_error_r;
  logic [gcbdt_pkg::DIST_W-1:0] dist_sat;

  function automatic logic [W-1:0] relax(input logic [W-1:0] cur, input logic [W-1:0] nb);
    logic [W-1:0] inc;
    begin
      inc = nb + W'(1);
      if (nb != gcbdt_pkg::FAR && inc < cur) begin
        return inc;
      end
      return cur;
    end
  endfunction

  assign rows_m1  = RW'(grid_cfg.rows - gcbdt_pkg::CNT_W'(1));
  assign cols_m1  = CW'(grid_cfg.cols - gcbdt_pkg::CNT_W'(1));
  assign own_addr = {row_r, col_r};
  assign nb_row   = cmd.dir_bwd ? (row_r + RW'(1)) : (row_r - RW'(1));
  assign nb_addr  = {nb_row, col_r};
  assign in_addr  = {in_row_index, in_col_index};
  assign addr_b   = cmd.sel_input ? in_addr : own_addr;

  assign in_err = ((in_req_type == gcbdt_pkg::REQ_WRITE) || (in_req_type == gcbdt_pkg::REQ_READ))
               && (({1'b0, in_row_index} >= grid_cfg.rows)
               ||  ({1'b0, in_col_index} >= grid_cfg.cols));

  assign sts.last_cell = cmd.dir_bwd ? ((row_r == '0) && (col_r == '0))
                                     : ((row_r == rows_m1) && (col_r == cols_m1));
  assign sts.out_valid = out_valid_r;

  // raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.fwd_init) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.bwd_init) begin
      row_r <= rows_m1;
      col_r <= cols_m1;
    end else if (cmd.step) begin
      if (!cmd.dir_bwd) begin
        if (col_r == cols_m1) begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end else begin
        if (col_r == '0) begin
          col_r <= cols_m1;
          row_r <= row_r - RW'(1);
        end else begin
          col_r <= col_r - CW'(1);
        end
      end
    end
  end

  // obstacle map
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_req_type == gcbdt_pkg::REQ_WRITE) && !in_err) begin
      obs_mem[in_addr] <= in_is_obstacle;
    end
    obs_rd_r <= obs_mem[own_addr];
  end

  // distance map, also used as the working array of both passes
  always_ff @(posedge clk) begin
    if (cmd.wr_fwd || cmd.wr_bwd) begin
      dist_mem[own_addr] <= d_nxt;
    end
    rd_a_r <= dist_mem[nb_addr];
    rd_b_r <= dist_mem[addr_b];
  end

  always_comb begin
    if (cmd.dir_bwd) begin
      base    = rd_b_r;
      vert_ok = (row_r != rows_m1);
      horz_ok = (col_r != cols_m1);
    end else begin
      base    = obs_rd_r ? '0 : gcbdt_pkg::FAR;
      vert_ok = (row_r != '0);
      horz_ok = (col_r != '0);
    end
    mid   = vert_ok ? relax(base, rd_a_r) : base;
    d_nxt = horz_ok ? relax(mid, prev_r) : mid;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_fwd || cmd.wr_bwd) begin
      prev_r <= d_nxt;
    end
    if (cmd.accept) begin
      req_r <= in_req_type;
      err_r <= in_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r        <= 1'b0;
      any_obstacle_r <= 1'b0;
    end else begin
      if (cmd.fwd_init) begin
        found_r <= 1'b0;
      end else if (cmd.wr_fwd && obs_rd_r) begin
        found_r <= 1'b1;
      end
      if (cmd.commit) begin
        any_obstacle_r <= found_r;
      end
    end
  end

  assign dist_sat = (rd_b_r > W'(gcbdt_pkg::DIST_MAX)) ? gcbdt_pkg::DIST_MAX
                                                       : rd_b_r[gcbdt_pkg::DIST_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_distance_r   <= '0;
      out_infinite_r   <= 1'b0;
      out_addr_error_r <= 1'b0;
      case (req_r)
        gcbdt_pkg::REQ_WRITE: begin
          out_addr_error_r <= err_r;
        end
        gcbdt_pkg::REQ_COMPUTE: begin
          out_infinite_r <= !any_obstacle_r;
        end
        gcbdt_pkg::REQ_READ: begin
          if (err_r) begin
            out_addr_error_r <= 1'b1;
          end else if (any_obstacle_r) begin
            out_distance_r <= dist_sat;
          end else begin
            out_infinite_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = out_distance_r;
  assign out_infinite   = out_infinite_r;
  assign out_addr_error = out_addr_error_r;

  `GCBDT_ASSERT_NOW(a_flags_exclusive, out_valid_r, !(out_infinite_r && out_addr_error_r), "infinite and address error flagged together")

endmodule

// ===== rtl/grid_city_block_distance_transform_top.sv =====
// City-block distance transform over a grid of up to 64 x 64 cells. Write items store one
// cell's obstacle bit and read items return one cell's distance; the memory is accessed on
// transfer and a response state then loads the output register. A compute item runs a forward
// and a backward raster pass over the configured rows x cols, reading then writing the distance
// memory for every cell in each pass. The memories need no clearing pass after reset; cells
// must be written before a compute uses them. The grid size registers are at byte addresses
// 0 (rows) and 4 (cols); the user must write them only while idle; the block does not enforce it.
// depends on gcbdt_pkg, gcbdt_cfg, gcbdt_ctrl and gcbdt_dp
module grid_city_block_distance_transform_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [5:0]                    in_row_index,
  input  logic [5:0]                    in_col_index,
  input  logic                          in_is_obstacle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [6:0]                    out_distance,
  output logic                          out_infinite,
  output logic                          out_addr_error
);

  gcbdt_pkg::grid_cfg_t  grid_cfg;
  gcbdt_pkg::ctrl_cmd_t  cmd;
  gcbdt_pkg::dp_sts_t    sts;

  gcbdt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .grid_cfg    (grid_cfg)
  );

  gcbdt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  gcbdt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .grid_cfg       (grid_cfg),
    .in_req_type    (in_req_type),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_is_obstacle (in_is_obstacle),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_distance   (out_distance),
    .out_infinite   (out_infinite),
    .out_addr_error (out_addr_error)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for grid_city_block_distance_transform_top: queued request driver, response
// monitor and a predictor that keeps its own obstacle and distance grids; depends on gcbdt_pkg
module tb;
  import gcbdt_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 32;
  localparam int FAR_DIST     = 32'hFFFF;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic             is_obstacle;
  } grid_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              infinite;
    logic              addr_error;
  } grid_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [5:0]  in_row_index = '0;
  logic [5:0]  in_col_index = '0;
  logic        in_is_obstacle = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_distance;
  logic        out_infinite;
  logic        out_addr_error;

  grid_city_block_distance_transform_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_is_obstacle (in_is_obstacle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_distance   (out_distance),
    .out_infinite   (out_infinite),
    .out_addr_error (out_addr_error)
  );

  // predictor state
  logic [CNT_W-1:0]  model_rows = 7'd64;
  logic [CNT_W-1:0]  model_cols = 7'd64;
  bit                obst_grid [CELLS];
  logic [DIST_W-1:0] dist_grid [CELLS];
  bit                grid_has_obstacle = 1'b0;
  int                relax_work [CELLS];

  // stimulus bookkeeping
  grid_req_t  pending_req_q [$];
  grid_resp_t expected_resp_q [$];
  bit         gen_written [CELLS];
  bit         gen_computed [CELLS];
  int         gen_rows = MAX_ROWS;
  int         gen_cols = MAX_COLS;
  int         queued_total = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         req_count [4];
  int         responses_checked = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         phase_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int eff_extent(input logic [CNT_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic int relax_step(input int cur, input int nb);
    if (nb != FAR_DIST && nb + 1 < cur) return nb + 1;
    return cur;
  endfunction

  // forward then backward raster pass over the configured area
  function automatic void run_distance_transform();
    int rows, cols, i, d;
    bit found;
    rows = eff_extent(model_rows, MAX_ROWS);
    cols = eff_extent(model_cols, MAX_COLS);
    found = 1'b0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        i = r * MAX_COLS + c;
        d = FAR_DIST;
        if (obst_grid[i]) begin
          d = 0;
          found = 1'b1;
        end
        if (r > 0) d = relax_step(d, relax_work[i - MAX_COLS]);
        if (c > 0) d = relax_step(d, relax_work[i - 1]);
        relax_work[i] = d;
      end
    end
    for (int r = rows - 1; r >= 0; r--) begin
      for (int c = cols - 1; c >= 0; c--) begin
        i = r * MAX_COLS + c;
        d = relax_work[i];
        if (r + 1 < rows) d = relax_step(d, relax_work[i + MAX_COLS]);
        if (c + 1 < cols) d = relax_step(d, relax_work[i + 1]);
        relax_work[i] = d;
        dist_grid[i] = (d > DIST_MAX) ? DIST_MAX : d[DIST_W-1:0];
      end
    end
    grid_has_obstacle = found;
  endfunction

  function automatic grid_resp_t predict_response(input grid_req_t rq);
    grid_resp_t rs;
    int idx;
    rs = '0;
    idx = rq.row_index * MAX_COLS + rq.col_index;
    if (rq.req_type == REQ_COMPUTE) begin
      run_distance_transform();
      rs.infinite = !grid_has_obstacle;
    end else if (rq.req_type == REQ_WRITE || rq.req_type == REQ_READ) begin
      if (rq.row_index >= eff_extent(model_rows, MAX_ROWS) ||
          rq.col_index >= eff_extent(model_cols, MAX_COLS)) begin
        rs.addr_error = 1'b1;
      end else if (rq.req_type == REQ_WRITE) begin
        obst_grid[idx] = rq.is_obstacle;
      end else if (grid_has_obstacle) begin
        rs.distance = dist_grid[idx];
      end else begin
        rs.infinite = 1'b1;
      end
    end
    return rs;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    grid_req_t nxt, acc;
    grid_resp_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        acc = {in_req_type, in_row_index, in_col_index, in_is_obstacle};
        predicted = predict_response(acc);
        expected_resp_q = {expected_resp_q, predicted};
        req_count[acc.req_type]++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_req_q.pop_front();
          in_valid       <= 1'b1;
          in_req_type    <= nxt.req_type;
          in_row_index   <= nxt.row_index;
          in_col_index   <= nxt.col_index;
          in_is_obstacle <= nxt.is_obstacle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin : check_responses
    grid_resp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_resp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: distance %0d infinite %0b error %0b",
                                    out_distance, out_infinite, out_addr_error));
        end else begin
          want = expected_resp_q.pop_front();
          if (out_distance !== want.distance)
            report_mismatch($sformatf("result %0d: distance %0d, expected %0d",
                                      responses_checked, out_distance, want.distance));
          if (out_infinite !== want.infinite)
            report_mismatch($sformatf("result %0d: infinite %0b, expected %0b",
                                      responses_checked, out_infinite, want.infinite));
          if (out_addr_error !== want.addr_error)
            report_mismatch($sformatf("result %0d: addr_error %0b, expected %0b",
                                      responses_checked, out_addr_error, want.addr_error));
          responses_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_resp_q.size());
      $display("[grid_city_block_distance_transform_top] ERROR");
      $finish;
    end
  end

  task automatic write_grid_reg(input logic reg_idx, input logic [CNT_W-1:0] value);
    logic [31:0] upper;
    upper = $urandom;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= {upper[31:CNT_W], value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    if (cfg_prdata !== {{(32-CNT_W){1'b0}}, value})
      report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                reg_idx, cfg_prdata, value));
    if (reg_idx == REG_ROWS) model_rows = value;
    else model_cols = value;
  endtask

  task automatic configure_grid(input logic [CNT_W-1:0] rows_val, input logic [CNT_W-1:0] cols_val);
    write_grid_reg(REG_ROWS, rows_val);
    write_grid_reg(REG_COLS, cols_val);
    gen_rows = eff_extent(rows_val, MAX_ROWS);
    gen_cols = eff_extent(cols_val, MAX_COLS);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_req_q.size() != 0 || in_valid || expected_resp_q.size() != 0);
  endtask

  task automatic queue_req(input logic [REQ_W-1:0] kind, input int r, input int c, input bit obs);
    grid_req_t rq;
    rq.req_type    = kind;
    rq.row_index   = r[ROW_W-1:0];
    rq.col_index   = c[COL_W-1:0];
    rq.is_obstacle = obs;
    pending_req_q = {pending_req_q, rq};
    queued_total++;
    if (kind == REQ_WRITE && r < gen_rows && c < gen_cols) gen_written[r * MAX_COLS + c] = 1'b1;
    if (kind == REQ_COMPUTE) begin
      for (int i = 0; i < gen_rows; i++)
        for (int j = 0; j < gen_cols; j++) gen_computed[i * MAX_COLS + j] = 1'b1;
    end
  endtask

  // unknown requests and out-of-range accesses
  task automatic queue_noise();
    int pick, r, c;
    pick = $urandom_range(2);
    if (pick == 0 || (gen_rows == MAX_ROWS && gen_cols == MAX_COLS)) begin
      queue_req(REQ_UNKNOWN, $urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1),
                1'($urandom_range(1)));
    end else begin
      if (gen_rows < MAX_ROWS && (gen_cols == MAX_COLS || $urandom_range(1))) begin
        r = $urandom_range(MAX_ROWS - 1, gen_rows);
        c = $urandom_range(MAX_COLS - 1);
      end else begin
        r = $urandom_range(MAX_ROWS - 1);
        c = $urandom_range(MAX_COLS - 1, gen_cols);
      end
      queue_req(pick == 1 ? REQ_WRITE : REQ_READ, r, c, 1'($urandom_range(1)));
    end
  endtask

  // read back earlier results, then fill the map, run the transform, read back; one to three rounds per size
  task automatic build_phase();
    int n, r, c, target, mode, cell_idx;
    bit obs;
    n = gen_rows * gen_cols;
    repeat ($urandom_range(4)) begin
      r = $urandom_range(gen_rows - 1);
      c = $urandom_range(gen_cols - 1);
      if (gen_computed[r * MAX_COLS + c]) queue_req(REQ_READ, r, c, 1'($urandom_range(1)));
    end
    repeat ($urandom_range(3, 1)) begin
      mode = $urandom_range(3);
      target = $urandom_range(n - 1);
      for (cell_idx = 0; cell_idx < n; cell_idx++) begin
        r = cell_idx / gen_cols;
        c = cell_idx % gen_cols;
        if (!gen_written[r * MAX_COLS + c] || $urandom_range(99) < 30) begin
          if ($urandom_range(9) == 0) queue_noise();
          case (mode)
            0: obs = 1'b0;
            1: obs = (cell_idx == target);
            2: obs = ($urandom_range(99) < 10);
            default: obs = ($urandom_range(99) < 50);
          endcase
          queue_req(REQ_WRITE, r, c, obs);
        end
      end
      queue_req(REQ_COMPUTE, $urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1),
                1'($urandom_range(1)));
      repeat ($urandom_range(n < 12 ? 2 * n : 24, 2)) begin
        if ($urandom_range(9) == 0) queue_noise();
        queue_req(REQ_READ, $urandom_range(gen_rows - 1), $urandom_range(gen_cols - 1),
                  1'($urandom_range(1)));
      end
    end
  endtask

  initial begin : run_test
    logic [CNT_W-1:0] rv, cv;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset size is the full grid: corner writes never fail, unknown requests do nothing
    queue_req(REQ_UNKNOWN, 63, 63, 1'b1);
    queue_req(REQ_UNKNOWN, 0, 0, 1'b0);
    queue_req(REQ_WRITE, 0, 0, 1'b1);
    queue_req(REQ_WRITE, 63, 63, 1'b1);
    queue_req(REQ_WRITE, 0, 63, 1'b0);
    queue_req(REQ_WRITE, 63, 0, 1'b0);
    wait_drained();

    // zero rows acts as one row; empty grid, stale results, errors
    configure_grid(7'd0, 7'd4);
    for (int c = 0; c < 4; c++) queue_req(REQ_WRITE, 0, c, 1'b0);
    queue_req(REQ_COMPUTE, 0, 0, 1'b0);
    queue_req(REQ_READ, 0, 2, 1'b0);
    queue_req(REQ_READ, 1, 0, 1'b0);
    queue_req(REQ_WRITE, 0, 4, 1'b1);
    queue_req(REQ_WRITE, 0, 3, 1'b1);
    queue_req(REQ_READ, 0, 3, 1'b0);
    queue_req(REQ_COMPUTE, 63, 63, 1'b1);
    queue_req(REQ_READ, 0, 0, 1'b1);
    queue_req(REQ_READ, 0, 3, 1'b0);
    queue_req(REQ_READ, 5, 1, 1'b0);
    queue_req(REQ_WRITE, 63, 63, 1'b1);
    queue_req(REQ_COMPUTE, 0, 0, 1'b0);
    queue_req(REQ_READ, 0, 1, 1'b0);

    while (queued_total < ITEM_TARGET) begin
      wait_drained();
      phase_count++;
      case (phase_count % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case ($urandom_range(11))
        0: begin rv = 7'd0; cv = CNT_W'($urandom_range(8, 1)); end
        1: begin rv = CNT_W'($urandom_range(127, 65)); cv = CNT_W'($urandom_range(3, 1)); end
        2: begin rv = 7'd64; cv = CNT_W'($urandom_range(4, 1)); end
        3: begin
          rv = CNT_W'($urandom_range(2, 1));
          cv = $urandom_range(1) ? 7'd64 : CNT_W'($urandom_range(127, 65));
        end
        4: begin rv = CNT_W'($urandom_range(8, 1)); cv = 7'd0; end
        default: begin rv = CNT_W'($urandom_range(8, 1)); cv = CNT_W'($urandom_range(8, 1)); end
      endcase
      configure_grid(rv, cv);
      build_phase();
    end

    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d writes, %0d transforms, %0d reads, %0d unknown requests over %0d sizes",
             req_count[REQ_WRITE], req_count[REQ_COMPUTE], req_count[REQ_READ],
             req_count[REQ_UNKNOWN], phase_count + 2);
    $display("%0d results checked, %0d mismatches", responses_checked, mismatches);
    if (mismatches == 0 && expected_resp_q.size() == 0) begin
      $display("[grid_city_block_distance_transform_top] OK");
    end else begin
      $display("[grid_city_block_distance_transform_top] ERROR");
    end
    $finish;
  end

endmodule
